/* rtl/sua_pkg.sv */
// Package with the word types and codes shared by the scatter unit allocator files.
package sua_pkg;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    localparam int SIZE_W  = 9;
    localparam int RID_W   = 16;
    localparam int ADDR_W  = 8;
    localparam int COUNT_W = 9;

    localparam logic [SIZE_W-1:0] UNITS_RESET = 9'd200;

    typedef logic [SIZE_W-1:0] units_t;

    typedef struct packed {
        logic               mode;
        logic [SIZE_W-1:0]  alloc_size;
        logic [RID_W-1:0]   release_id;
    } req_t;

    typedef struct packed {
        logic               ok;
        logic [RID_W-1:0]   assigned_id;
        logic [ADDR_W-1:0]  first_address;
        logic [COUNT_W-1:0] units_changed;
        logic [COUNT_W-1:0] units_in_use;
    } rsp_t;

endpackage

/* rtl/sua_stream_if.sv */
// Valid/ready channel interface that carries one word of any payload type.
interface sua_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/sua_owner_ram.sv */
// Owner map memory with one write port and one registered read port.
module sua_owner_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 17
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/scatter_unit_allocator_core.sv */
// Top level of the scatter unit allocator: owner map, request sequencer and result register.
//
// The block keeps an owner map of MAX_UNITS units in a single-port-read memory and serves
// one request at a time, walking the map one unit per cycle. An allocate reads the first
// memory_units units (capped at MAX_UNITS) once to count free units and, if the size is
// nonzero and enough units are free, once more to claim the lowest ones; a release reads
// all MAX_UNITS units once. Reads of the owner memory are registered. After reset the map
// is cleared one unit per cycle, so no request is taken until every unit has been cleared;
// the configuration word is accepted at any time.
module scatter_unit_allocator_core
    import sua_pkg::*;
#(
    parameter int MAX_UNITS = 256,
    parameter int ID_BITS   = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    sua_stream_if.sink   req,
    sua_stream_if.source rsp,
    sua_stream_if.sink   cfg
);

    localparam int AW = $clog2(MAX_UNITS);
    localparam int CW = $clog2(MAX_UNITS + 1);
    localparam int LW = (CW > SIZE_W) ? CW : SIZE_W;
    localparam int MW = ID_BITS + 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COUNT,
        ST_CLAIM,
        ST_RELEASE,
        ST_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic                pend_reg, pend_next;
    logic [AW-1:0]       paddr_reg, paddr_next;
    logic [CW-1:0]       lim_reg, lim_next;
    logic                mode_reg, mode_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [ID_BITS-1:0]  rel_reg, rel_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       left_reg, left_next;
    logic [AW-1:0]       first_reg, first_next;
    logic                have_first_reg, have_first_next;
    logic                ok_reg, ok_next;
    logic [CW-1:0]       used_reg, used_next;
    logic [ID_BITS-1:0]  num_reg, num_next;
    rsp_t                rsp_data_reg, rsp_data_next;
    logic                rsp_valid_reg, rsp_valid_next;
    units_t              units_reg;

    logic                we;
    logic [AW-1:0]       waddr;
    logic [MW-1:0]       wdata;
    logic [MW-1:0]       rdata;
    logic                scanning;
    logic [CW-1:0]       end_w;
    logic                issue;
    logic                scan_done;
    logic                r_valid;
    logic [ID_BITS-1:0]  r_owner;
    logic [CW-1:0]       lim_now;
    rsp_t                result;

    sua_owner_ram #(
        .DEPTH (MAX_UNITS),
        .WIDTH (MW)
    ) u_owner_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rdata)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    assign scanning  = (state_reg == ST_COUNT) || (state_reg == ST_CLAIM)
                       || (state_reg == ST_RELEASE);
    assign end_w     = (state_reg == ST_RELEASE) ? CW'(MAX_UNITS) : lim_reg;
    assign issue     = scanning && (idx_reg < end_w);
    assign scan_done = scanning && !issue && !pend_reg;
    assign r_valid   = rdata[ID_BITS];
    assign r_owner   = rdata[ID_BITS-1:0];
    assign lim_now   = (LW'(units_reg) > LW'(MAX_UNITS)) ? CW'(MAX_UNITS) : CW'(units_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            units_reg <= UNITS_RESET;
        end
        else if (cfg.valid)
        begin
            units_reg <= cfg.data;
        end
    end

    always_comb
    begin
        result               = '0;
        result.ok            = ok_reg;
        result.units_in_use  = COUNT_W'(used_reg);
        if (mode_reg == MODE_ALLOC)
        begin
            if (ok_reg)
            begin
                result.assigned_id   = RID_W'(num_reg - ID_BITS'(1));
                result.first_address = ADDR_W'(first_reg);
                result.units_changed = COUNT_W'(size_reg);
            end
        end
        else
        begin
            result.units_changed = COUNT_W'(cnt_reg);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        pend_next       = issue;
        paddr_next      = idx_reg[AW-1:0];
        lim_next        = lim_reg;
        mode_next       = mode_reg;
        size_next       = size_reg;
        rel_next        = rel_reg;
        cnt_next        = cnt_reg;
        left_next       = left_reg;
        first_next      = first_reg;
        have_first_next = have_first_reg;
        ok_next         = ok_reg;
        used_next       = used_reg;
        num_next        = num_reg;
        rsp_data_next   = rsp_data_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        we              = 1'b0;
        waddr           = paddr_reg;
        wdata           = '0;

        if (issue)
        begin
            idx_next = idx_reg + CW'(1);
        end

        case (state_reg)
            ST_CLEAR:
            begin
                we       = 1'b1;
                waddr    = idx_reg[AW-1:0];
                idx_next = idx_reg + CW'(1);
                if (idx_reg == CW'(MAX_UNITS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next       = req.data.mode;
                    size_next       = req.data.alloc_size;
                    rel_next        = ID_BITS'(req.data.release_id);
                    lim_next        = lim_now;
                    idx_next        = '0;
                    cnt_next        = '0;
                    have_first_next = 1'b0;
                    first_next      = '0;
                    ok_next         = 1'b0;
                    state_next      = (req.data.mode == MODE_ALLOC) ? ST_COUNT : ST_RELEASE;
                end
            end
            ST_COUNT:
            begin
                if (pend_reg && !r_valid)
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                if (scan_done)
                begin
                    idx_next = '0;
                    if ((size_reg != '0) && (LW'(size_reg) <= LW'(cnt_reg)))
                    begin
                        left_next  = CW'(size_reg);
                        state_next = ST_CLAIM;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_CLAIM:
            begin
                if (pend_reg && !r_valid && (left_reg != '0))
                begin
                    we        = 1'b1;
                    wdata     = {1'b1, num_reg};
                    left_next = left_reg - CW'(1);
                    if (!have_first_reg)
                    begin
                        first_next      = paddr_reg;
                        have_first_next = 1'b1;
                    end
                end
                if (scan_done)
                begin
                    ok_next    = 1'b1;
                    used_next  = used_reg + CW'(size_reg);
                    num_next   = num_reg + ID_BITS'(1);
                    state_next = ST_FINISH;
                end
            end
            ST_RELEASE:
            begin
                if (pend_reg && r_valid && (r_owner == rel_reg))
                begin
                    we       = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                end
                if (scan_done)
                begin
                    ok_next    = (cnt_reg != '0);
                    used_next  = used_reg - cnt_reg;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_data_next  = result;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            paddr_reg      <= '0;
            lim_reg        <= '0;
            mode_reg       <= MODE_ALLOC;
            size_reg       <= '0;
            rel_reg        <= '0;
            cnt_reg        <= '0;
            left_reg       <= '0;
            first_reg      <= '0;
            have_first_reg <= 1'b0;
            ok_reg         <= 1'b0;
            used_reg       <= '0;
            num_reg        <= '0;
            rsp_data_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pend_reg       <= pend_next;
            paddr_reg      <= paddr_next;
            lim_reg        <= lim_next;
            mode_reg       <= mode_next;
            size_reg       <= size_next;
            rel_reg        <= rel_next;
            cnt_reg        <= cnt_next;
            left_reg       <= left_next;
            first_reg      <= first_next;
            have_first_reg <= have_first_next;
            ok_reg         <= ok_next;
            used_reg       <= used_next;
            num_reg        <= num_next;
            rsp_data_reg   <= rsp_data_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

endmodule

/* rtl/sua_checker.sv */
// Port-level checker for the scatter unit allocator and the bind that attaches it.
module sua_checker
    import sua_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp_data
);

    // A request occupies the block, so it cannot take another one in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while the previous one was in progress");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result word changed before it was taken");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.ok |-> (rsp_data.assigned_id == '0)
            && (rsp_data.first_address == '0) && (rsp_data.units_changed == '0))
        else $error("failed request reported nonzero fields");

    a_ok_changes: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.ok |-> (rsp_data.units_changed != '0))
        else $error("successful request changed no units");

endmodule

bind scatter_unit_allocator_core sua_checker u_sua_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

/* test/scatter_unit_allocator_core_tb.sv */
// Self-checking testbench for scatter_unit_allocator_core with random stimulus and idling.
module scatter_unit_allocator_core_tb;
    import sua_pkg::*;

    localparam int UNIT_COUNT  = 256;
    localparam int PERIOD      = 20;
    localparam int CYCLE_LIMIT = 5000000;
    localparam int PHASES      = 7;

    logic clk = 1'b0;
    logic rst_n;

    sua_stream_if #(.T(req_t))   req_if ();
    sua_stream_if #(.T(rsp_t))   rsp_if ();
    sua_stream_if #(.T(units_t)) cfg_if ();

    scatter_unit_allocator_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    always #(PERIOD / 2) clk = ~clk;

    logic             unit_owned [UNIT_COUNT] = '{default: 1'b0};
    logic [RID_W-1:0] unit_id    [UNIT_COUNT] = '{default: '0};
    logic [RID_W-1:0] next_id    = '0;
    units_t           units_used = '0;
    units_t           units_cfg  = UNITS_RESET;

    req_t   pending_reqs  [$];
    rsp_t   expected_rsps [$];
    units_t pending_cfg   [$];

    int unsigned bad_results = 0;
    int unsigned cycle_count = 0;
    int unsigned ids_issued  = 0;
    int          req_gap     = 0;
    int          rsp_stall   = 0;
    bit          quiet       = 1'b0;

    units_t phase_units [PHASES] = '{9'd256, 9'd1, 9'd0, 9'd37, 9'd511, 9'd128, 9'd256};
    int     phase_items [PHASES] = '{200, 40, 20, 120, 100, 100, 80};

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 400);
    endfunction

    function automatic rsp_t apply_request(req_t r);
        rsp_t o;
        int   lim;
        int   free_units;
        int   left;
        bit   have_first;
        o = '0;
        lim = (units_cfg > UNIT_COUNT) ? UNIT_COUNT : int'(units_cfg);
        if (r.mode == MODE_ALLOC)
        begin
            free_units = 0;
            for (int i = 0; i < lim; i++)
                if (!unit_owned[i])
                    free_units++;
            if (r.alloc_size != 0 && r.alloc_size <= free_units)
            begin
                left = r.alloc_size;
                have_first = 1'b0;
                o.assigned_id = next_id;
                for (int i = 0; i < lim && left != 0; i++)
                begin
                    if (!unit_owned[i])
                    begin
                        unit_owned[i] = 1'b1;
                        unit_id[i] = next_id;
                        if (!have_first)
                        begin
                            o.first_address = ADDR_W'(i);
                            have_first = 1'b1;
                        end
                        left--;
                    end
                end
                next_id = next_id + 1'b1;
                units_used = units_used + r.alloc_size;
                o.units_changed = r.alloc_size;
                o.ok = 1'b1;
            end
        end
        else
        begin
            for (int i = 0; i < UNIT_COUNT; i++)
            begin
                if (unit_owned[i] && unit_id[i] == r.release_id)
                begin
                    unit_owned[i] = 1'b0;
                    unit_id[i] = '0;
                    o.units_changed = o.units_changed + 1'b1;
                end
            end
            if (o.units_changed != 0)
            begin
                o.ok = 1'b1;
                units_used = units_used - o.units_changed;
            end
        end
        o.units_in_use = units_used;
        return o;
    endfunction

    function automatic void push_request(logic mode, int size, int rid);
        req_t r;
        r.mode = mode;
        r.alloc_size = SIZE_W'(size);
        r.release_id = RID_W'(rid);
        pending_reqs.push_back(r);
    endfunction

    function automatic void push_random_request();
        int roll;
        int size_roll;
        int lo;
        roll = $urandom_range(0, 99);
        if (roll < 52)
        begin
            size_roll = $urandom_range(0, 99);
            if (size_roll < 70)
                push_request(MODE_ALLOC, $urandom_range(1, 8), $urandom);
            else if (size_roll < 90)
                push_request(MODE_ALLOC, $urandom_range(9, 40), $urandom);
            else if (size_roll < 97)
                push_request(MODE_ALLOC, $urandom_range(41, 256), $urandom);
            else
                push_request(MODE_ALLOC, 0, $urandom);
            ids_issued++;
        end
        else if (roll < 92)
        begin
            lo = (ids_issued > 20) ? int'(ids_issued) - 20 : 0;
            push_request(MODE_RELEASE, $urandom_range(0, 256), $urandom_range(lo, ids_issued));
        end
        else
            push_request(MODE_RELEASE, $urandom_range(0, 256), $urandom);
    endfunction

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_units(units_t value);
        repeat (8) @(negedge clk);
        pending_cfg.push_back(value);
        while (pending_cfg.size() != 0 || cfg_if.valid)
            @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic v_next;
        req_t d_next;
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            req_if.data <= '0;
        end
        else
        begin
            v_next = req_if.valid;
            d_next = req_if.data;
            if (req_if.valid && req_if.ready)
            begin
                expected_rsps.push_back(apply_request(req_if.data));
                v_next = 1'b0;
                req_gap = quiet ? 0 : pick_gap();
            end
            else if (!v_next && req_gap != 0)
                req_gap--;
            if (!v_next && req_gap == 0 && pending_reqs.size() != 0)
            begin
                v_next = 1'b1;
                d_next = pending_reqs.pop_front();
            end
            req_if.valid <= v_next;
            req_if.data <= d_next;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        logic   v_next;
        units_t d_next;
        if (!rst_n)
        begin
            cfg_if.valid <= 1'b0;
            cfg_if.data <= UNITS_RESET;
        end
        else
        begin
            v_next = cfg_if.valid;
            d_next = cfg_if.data;
            if (cfg_if.valid && cfg_if.ready)
            begin
                units_cfg = cfg_if.data;
                v_next = 1'b0;
            end
            if (!v_next && pending_cfg.size() != 0)
            begin
                v_next = 1'b1;
                d_next = pending_cfg.pop_front();
            end
            cfg_if.valid <= v_next;
            cfg_if.data <= d_next;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        rsp_t got;
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                got = rsp_if.data;
                if (expected_rsps.size() == 0)
                begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("unexpected word: ok=%0d id=%0d first=%0d chg=%0d use=%0d",
                                 got.ok, got.assigned_id, got.first_address,
                                 got.units_changed, got.units_in_use);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (got.ok !== want.ok || got.assigned_id !== want.assigned_id ||
                        got.first_address !== want.first_address ||
                        got.units_changed !== want.units_changed ||
                        got.units_in_use !== want.units_in_use)
                    begin
                        bad_results++;
                        if (bad_results <= 10)
                        begin
                            $display("mismatch exp ok=%0d id=%0d first=%0d chg=%0d use=%0d",
                                     want.ok, want.assigned_id, want.first_address,
                                     want.units_changed, want.units_in_use);
                            $display("         got ok=%0d id=%0d first=%0d chg=%0d use=%0d",
                                     got.ok, got.assigned_id, got.first_address,
                                     got.units_changed, got.units_in_use);
                        end
                    end
                end
            end
            if (rsp_stall == 0 && !quiet && $urandom_range(0, 31) == 0)
                rsp_stall = pick_gap();
            if (rsp_stall != 0)
            begin
                rsp_stall--;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[scatter_unit_allocator_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data = UNITS_RESET;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_request(MODE_ALLOC, 0, 16'hFFFF);
        push_request(MODE_RELEASE, 256, 0);
        push_request(MODE_ALLOC, 1, 0);
        push_request(MODE_ALLOC, 256, 16'h5555);
        push_request(MODE_ALLOC, 3, 16'hAAAA);
        push_request(MODE_ALLOC, 2, 0);
        push_request(MODE_RELEASE, 0, 1);
        push_request(MODE_ALLOC, 5, 0);
        push_request(MODE_RELEASE, 9'h1FF, 16'hFFFF);
        push_request(MODE_ALLOC, 193, 0);
        push_request(MODE_ALLOC, 192, 0);
        push_request(MODE_ALLOC, 1, 0);
        push_request(MODE_RELEASE, 0, 3);
        push_request(MODE_ALLOC, 5, 0);
        push_request(MODE_RELEASE, 0, 16'hAAAA);
        push_request(MODE_RELEASE, 0, 16'h5555);
        push_request(MODE_RELEASE, 0, 5);
        push_request(MODE_RELEASE, 0, 4);
        push_request(MODE_RELEASE, 0, 0);
        push_request(MODE_RELEASE, 0, 2);
        ids_issued = 6;
        repeat (200) push_random_request();
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            write_units(phase_units[p]);
            quiet = (p % 3 == 1);
            if (p == 0)
            begin
                wait_idle();
                push_request(MODE_ALLOC, 256, 0);
                wait_idle();
                push_request(MODE_RELEASE, 0, next_id - 1'b1);
            end
            repeat (phase_items[p]) push_random_request();
            wait_idle();
        end

        quiet = 1'b0;
        repeat (600) @(negedge clk);
        if (bad_results == 0)
            $display("[scatter_unit_allocator_core] OK");
        else
            $display("[scatter_unit_allocator_core] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/sua_pkg.sv
rtl/sua_stream_if.sv
rtl/sua_owner_ram.sv
rtl/scatter_unit_allocator_core.sv
rtl/sua_checker.sv
test/scatter_unit_allocator_core_tb.sv
